// ----- sv/dsf_pkg.sv -----
// Shared constants and types of the damped spring force pipeline.
`default_nettype none

package dsf_pkg;

  localparam int SQ_STEPS  = 33;
  localparam int DIV_STEPS = 31;

  localparam logic [1:0] CFG_STIFFNESS = 2'd0;
  localparam logic [1:0] CFG_DAMPING   = 2'd1;
  localparam logic [1:0] CFG_REST      = 2'd2;

  typedef struct packed {
    logic [2:0][32:0] d;
    logic [2:0][32:0] dv;
    logic             zero;
  } sq_side_t;

  typedef struct packed {
    logic [2:0][32:0] dv;
    logic [32:0]      len;
    logic [2:0]       neg;
    logic             zero;
  } div_side_t;

endpackage

`default_nettype wire

// ----- sv/dsf_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module dsf_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [65:0]        in_n,
  input  dsf_pkg::sq_side_t  in_side,
  output logic               out_valid,
  output logic [32:0]        out_root,
  output dsf_pkg::sq_side_t  out_side
);

  localparam int N = dsf_pkg::SQ_STEPS;

  logic              v_r    [N];
  logic [65:0]       n_r    [N];
  logic [35:0]       rem_r  [N];
  logic [32:0]       root_r [N];
  dsf_pkg::sq_side_t side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic              v_s;
    logic [65:0]       n_s;
    logic [35:0]       rem_s;
    logic [32:0]       root_s;
    dsf_pkg::sq_side_t side_s;
    logic [35:0]       cur;
    logic [35:0]       trial;
    logic              ge;
    logic [35:0]       rem_nxt;
    logic [32:0]       root_nxt;

    if (k == 0) begin : g_first
      assign v_s    = in_valid;
      assign n_s    = in_n;
      assign rem_s  = '0;
      assign root_s = '0;
      assign side_s = in_side;
    end else begin : g_next
      assign v_s    = v_r[k-1];
      assign n_s    = n_r[k-1];
      assign rem_s  = rem_r[k-1];
      assign root_s = root_r[k-1];
      assign side_s = side_r[k-1];
    end

    assign cur      = {rem_s[33:0], n_s[65-2*k -: 2]};
    assign trial    = {1'b0, root_s, 2'b01};
    assign ge       = (cur >= trial);
    assign rem_nxt  = ge ? (cur - trial) : cur;
    assign root_nxt = {root_s[31:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]    <= n_s;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_s;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

`default_nettype wire

// ----- sv/dsf_div.sv -----
// Three-lane pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module dsf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [2:0][32:0]   in_mag,
  input  dsf_pkg::div_side_t in_side,
  output logic               out_valid,
  output logic [2:0][30:0]   out_q,
  output dsf_pkg::div_side_t out_side
);

  localparam int N = dsf_pkg::DIV_STEPS;

  logic               v_r    [N];
  logic [2:0][34:0]   r_r    [N];
  logic [2:0][30:0]   q_r    [N];
  dsf_pkg::div_side_t side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic               v_s;
    logic [2:0][34:0]   r_s;
    logic [2:0][30:0]   q_s;
    dsf_pkg::div_side_t side_s;
    logic [2:0][34:0]   r_nxt;
    logic [2:0][30:0]   q_nxt;

    if (k == 0) begin : g_first
      assign v_s    = in_valid;
      assign side_s = in_side;
      assign q_s    = '0;
      for (genvar i = 0; i < 3; i++) begin : g_init
        assign r_s[i] = {2'b00, in_mag[i]};
      end
    end else begin : g_next
      assign v_s    = v_r[k-1];
      assign r_s    = r_r[k-1];
      assign q_s    = q_r[k-1];
      assign side_s = side_r[k-1];
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [34:0] dvs;
      logic        ge;
      logic [34:0] diff;
      assign dvs        = {2'b00, side_s.len};
      assign ge         = (r_s[i] >= dvs);
      assign diff       = ge ? (r_s[i] - dvs) : r_s[i];
      assign r_nxt[i]   = {diff[33:0], 1'b0};
      assign q_nxt[i]   = {q_s[i][29:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]    <= r_nxt;
        q_r[k]    <= q_nxt;
        side_r[k] <= side_s;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_q     = q_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

`default_nettype wire

// ----- sv/damped_spring_force.sv -----
// Damped spring force between two points: top level with stream ports and registers.
// One spring per clock cycle enters and leaves the pipeline, whose depth is set mainly
// by the 33-stage square root and the 31-stage divider that forms the unit direction.
// A result that is not taken holds the whole pipeline, and in_tready falls with it.
// Forces are signed Q16.16 and saturate; coincident points give zero force and raise
// zero_length. Registers must be written only while the pipeline is empty; unchecked.
`default_nettype none

module damped_spring_force (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
  // vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z
  input  logic [383:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // force_x, force_y, force_z
  output logic [95:0]  out_tdata,
  // zero_length
  output logic [0:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  logic [31:0] ks_r;
  logic [31:0] kd_r;
  logic [31:0] rest_r;
  logic        adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r   <= 32'd1310720;
      kd_r   <= 32'd13107;
      rest_r <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_addr)
        dsf_pkg::CFG_STIFFNESS: ks_r   <= cfg_wdata;
        dsf_pkg::CFG_DAMPING:   kd_r   <= cfg_wdata;
        dsf_pkg::CFG_REST:      rest_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // valid bits
  logic v0_r, v1_r, v2_r, vu_r, vm1_r, vm2_r, vm3_r, vm4_r, vm5_r, out_valid_r;
  logic sq_valid, dv_valid;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // stage 0: differences
  logic [2:0][32:0] d0_r, dv0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d0_r[i]  <= {in_tdata[32*(3+i)+31], in_tdata[32*(3+i) +: 32]}
                  - {in_tdata[32*i+31], in_tdata[32*i +: 32]};
        dv0_r[i] <= {in_tdata[32*(6+i)+31], in_tdata[32*(6+i) +: 32]}
                  - {in_tdata[32*(9+i)+31], in_tdata[32*(9+i) +: 32]};
      end
    end
  end

  // stage 1: squares
  logic [2:0][32:0] d1_r, dv1_r;
  logic [2:0][64:0] sq1_r;

  always_ff @(posedge clk) begin
    logic [32:0] m;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        m = d0_r[i][32] ? (~d0_r[i] + 33'd1) : d0_r[i];
        sq1_r[i] <= m[32] ? {1'b1, 64'd0} : {1'b0, 64'(m[31:0] * m[31:0])};
      end
      d1_r  <= d0_r;
      dv1_r <= dv0_r;
    end
  end

  // stage 2: squared length
  logic [65:0]       n2_r;
  dsf_pkg::sq_side_t side2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      n2_r         <= 66'(sq1_r[0]) + 66'(sq1_r[1]) + 66'(sq1_r[2]);
      side2_r.d    <= d1_r;
      side2_r.dv   <= dv1_r;
      side2_r.zero <= (d1_r == '0);
    end
  end

  logic [32:0]       len_s;
  dsf_pkg::sq_side_t sq_side;

  dsf_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v2_r),
    .in_n      (n2_r),
    .in_side   (side2_r),
    .out_valid (sq_valid),
    .out_root  (len_s),
    .out_side  (sq_side)
  );

  logic [2:0][32:0]   div_mag;
  dsf_pkg::div_side_t div_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_mag[i]    = sq_side.d[i][32] ? (~sq_side.d[i] + 33'd1) : sq_side.d[i];
      div_in.neg[i] = sq_side.d[i][32];
    end
    div_in.dv   = sq_side.dv;
    div_in.len  = len_s;
    div_in.zero = sq_side.zero;
  end

  logic [2:0][30:0]   q_s;
  dsf_pkg::div_side_t dside;

  dsf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sq_valid),
    .in_mag    (div_mag),
    .in_side   (div_in),
    .out_valid (dv_valid),
    .out_q     (q_s),
    .out_side  (dside)
  );

  // unit vector and length error
  logic [2:0][31:0] uu_r;
  logic [2:0][32:0] dvu_r;
  logic [34:0]      diffu_r;
  logic             zu_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        uu_r[i] <= dside.neg[i] ? (~{1'b0, q_s[i]} + 32'd1) : {1'b0, q_s[i]};
      end
      dvu_r   <= dside.dv;
      diffu_r <= {2'b00, dside.len} - {3'b000, rest_r};
      zu_r    <= dside.zero;
    end
  end

  // M1: velocity projection products, spring term partial products
  logic [2:0][62:0] pdv1_r;
  logic [2:0]       pneg1_r;
  logic [63:0]      slo1_r;
  logic [33:0]      shi1_r;
  logic             sneg1_r;
  logic [2:0][31:0] u1_r;
  logic             z1_r;

  always_ff @(posedge clk) begin
    logic [30:0] um;
    logic [32:0] vm;
    logic [34:0] dm;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        um = uu_r[i][31] ? 31'(~uu_r[i] + 32'd1) : uu_r[i][30:0];
        vm = dvu_r[i][32] ? (~dvu_r[i] + 33'd1) : dvu_r[i];
        pdv1_r[i]  <= vm[32] ? {um, 32'd0} : 63'(vm[31:0] * um);
        pneg1_r[i] <= dvu_r[i][32] ^ uu_r[i][31];
      end
      dm      = diffu_r[34] ? (~diffu_r + 35'd1) : diffu_r;
      slo1_r  <= 64'(ks_r * dm[31:0]);
      shi1_r  <= 34'(ks_r * dm[33:32]);
      sneg1_r <= diffu_r[34];
      u1_r    <= uu_r;
      z1_r    <= zu_r;
    end
  end

  // M2: relative speed, spring term
  logic [36:0]      rel2_r;
  logic [51:0]      s2_r;
  logic [2:0][31:0] u2_r;
  logic             z2_r;

  always_ff @(posedge clk) begin
    logic [36:0] acc;
    logic [36:0] tv;
    logic [65:0] sm;
    logic [51:0] sv;
    if (adv) begin
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        tv  = {4'b0000, pdv1_r[i][62:30]};
        acc = acc + (pneg1_r[i] ? (~tv + 37'd1) : tv);
      end
      rel2_r <= acc;
      sm     = 66'({shi1_r, 32'd0}) + 66'(slo1_r);
      sv     = {2'b00, sm[65:16]};
      s2_r   <= sneg1_r ? (~sv + 52'd1) : sv;
      u2_r   <= u1_r;
      z2_r   <= z1_r;
    end
  end

  // M3: damping term partial products
  logic [63:0]      dlo3_r;
  logic [35:0]      dhi3_r;
  logic             dneg3_r;
  logic [51:0]      s3_r;
  logic [2:0][31:0] u3_r;
  logic             z3_r;

  always_ff @(posedge clk) begin
    logic [36:0] rm;
    if (adv) begin
      rm      = rel2_r[36] ? (~rel2_r + 37'd1) : rel2_r;
      dlo3_r  <= 64'(kd_r * rm[31:0]);
      dhi3_r  <= 36'(kd_r * rm[35:32]);
      dneg3_r <= rel2_r[36];
      s3_r    <= s2_r;
      u3_r    <= u2_r;
      z3_r    <= z2_r;
    end
  end

  // M4: scalar force
  logic [53:0]      f4_r;
  logic [2:0][31:0] u4_r;
  logic             z4_r;

  always_ff @(posedge clk) begin
    logic [67:0] dm;
    logic [53:0] dd;
    if (adv) begin
      dm   = 68'({dhi3_r, 32'd0}) + 68'(dlo3_r);
      dd   = {2'b00, dm[67:16]};
      f4_r <= {{2{s3_r[51]}}, s3_r} - (dneg3_r ? (~dd + 54'd1) : dd);
      u4_r <= u3_r;
      z4_r <= z3_r;
    end
  end

  // M5: force components, partial products
  logic [2:0][62:0] plo5_r;
  logic [2:0][51:0] phi5_r;
  logic [2:0]       neg5_r;
  logic             z5_r;

  always_ff @(posedge clk) begin
    logic [53:0] fm;
    logic [30:0] um;
    if (adv) begin
      fm = f4_r[53] ? (~f4_r + 54'd1) : f4_r;
      for (int i = 0; i < 3; i++) begin
        um = u4_r[i][31] ? 31'(~u4_r[i] + 32'd1) : u4_r[i][30:0];
        plo5_r[i] <= 63'(fm[31:0] * um);
        phi5_r[i] <= 52'(fm[52:32] * um);
        neg5_r[i] <= f4_r[53] ^ u4_r[i][31];
      end
      z5_r <= z4_r;
    end
  end

  // M6: shift, saturate
  logic [2:0][31:0] force_r;
  logic             zl_r;

  always_ff @(posedge clk) begin
    logic [83:0] pm;
    logic [53:0] q;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pm = 84'({phi5_r[i], 32'd0}) + 84'(plo5_r[i]);
        q  = pm[83:30];
        if (z5_r) begin
          force_r[i] <= '0;
        end else if (!neg5_r[i]) begin
          force_r[i] <= (|q[53:31]) ? 32'h7FFF_FFFF : {1'b0, q[30:0]};
        end else if ((|q[53:32]) || (q[31] && (|q[30:0]))) begin
          force_r[i] <= 32'h8000_0000;
        end else begin
          force_r[i] <= ~q[31:0] + 32'd1;
        end
      end
      zl_r <= z5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      vu_r        <= 1'b0;
      vm1_r       <= 1'b0;
      vm2_r       <= 1'b0;
      vm3_r       <= 1'b0;
      vm4_r       <= 1'b0;
      vm5_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r        <= in_tvalid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      vu_r        <= dv_valid;
      vm1_r       <= vu_r;
      vm2_r       <= vm1_r;
      vm3_r       <= vm2_r;
      vm4_r       <= vm3_r;
      vm5_r       <= vm4_r;
      out_valid_r <= vm5_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {force_r[2], force_r[1], force_r[0]};
  assign out_tuser[0] = zl_r;

  a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("zero_length result with nonzero force");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vu_r && !adv) |=> vu_r)
    else $error("item lost in pipeline during stall");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench for the damped spring force pipeline: random and directed springs, scoreboard check.
`default_nettype none

class spring_force_board;
  logic [31:0] ks, kd, rest;
  logic [96:0] pending_forces[$];
  int errors;

  function new();
    ks = 32'd1310720;
    kd = 32'd13107;
    rest = 32'd65536;
    errors = 0;
  endfunction

  static function logic signed [127:0] mul_shr(logic signed [127:0] a, logic signed [127:0] b,
                                               int sh);
    logic signed [127:0] p;
    logic signed [127:0] m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = m >>> sh;
    return (p < 0) ? -m : m;
  endfunction

  function void note_spring(logic [383:0] item);
    logic signed [127:0] d[3], dv[3], u[3];
    logic [127:0] norm, len, cand;
    logic signed [127:0] rel, s_term, d_term, f, fc;
    logic [31:0] fo[3];
    rel = 0;
    norm = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed(item[32*(3+i) +: 32]) - $signed(item[32*i +: 32]);
      dv[i] = $signed(item[32*(6+i) +: 32]) - $signed(item[32*(9+i) +: 32]);
      norm += d[i] * d[i];
    end
    if (norm == 0) begin
      pending_forces.push_back({1'b1, 96'd0});
      return;
    end
    len = 0;
    for (int b = 32; b >= 0; b--) begin
      cand = len | (128'd1 << b);
      if (cand * cand <= norm) len = cand;
    end
    for (int i = 0; i < 3; i++) begin
      u[i] = (d[i] * (128'sd1 <<< 30)) / $signed(len);
      rel += mul_shr(dv[i], u[i], 30);
    end
    s_term = mul_shr($signed({96'd0, ks}), $signed(len) - $signed({96'd0, rest}), 16);
    d_term = mul_shr($signed({96'd0, kd}), rel, 16);
    f = s_term - d_term;
    for (int i = 0; i < 3; i++) begin
      fc = mul_shr(f, u[i], 30);
      if (fc > 128'sd2147483647) fc = 128'sd2147483647;
      if (fc < -128'sd2147483648) fc = -128'sd2147483648;
      fo[i] = fc[31:0];
    end
    pending_forces.push_back({1'b0, fo[2], fo[1], fo[0]});
  endfunction

  function void check_force(logic [95:0] data, logic zl);
    logic [96:0] exp_r;
    if (pending_forces.size() == 0) begin
      $display("%0t unexpected transaction: force %h zero_length %b", $time, data, zl);
      errors++;
      return;
    end
    exp_r = pending_forces.pop_front();
    for (int i = 0; i < 3; i++)
      if (exp_r[32*i +: 32] !== data[32*i +: 32]) begin
        $display("%0t force[%0d] expected %h actual %h", $time, i, exp_r[32*i +: 32],
                 data[32*i +: 32]);
        errors++;
      end
    if (exp_r[96] !== zl) begin
      $display("%0t zero_length expected %b actual %b", $time, exp_r[96], zl);
      errors++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 74;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [383:0] in_tdata;
  logic [95:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_we;
  logic [1:0] cfg_addr;
  logic [31:0] cfg_wdata;
  bit calm;

  spring_force_board board = new();

  damped_spring_force dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("[damped_spring_force] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_force(out_tdata, out_tuser[0]);
  end

  // receiver stalls in bursts
  initial begin
    int n;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!calm && $urandom_range(3) == 0) begin
        n = $urandom_range(18, 1);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(20, 1)) @(posedge clk);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == dsf_pkg::CFG_STIFFNESS) board.ks = val;
    else if (idx == dsf_pkg::CFG_DAMPING) board.kd = val;
    else if (idx == dsf_pkg::CFG_REST) board.rest = val;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending_forces.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_spring(logic [383:0] item);
    if (!calm && $urandom_range(4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= item;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_spring(item);
  endtask

  function automatic logic [31:0] rnd_word(int mode);
    case (mode)
      0: return {$urandom};
      1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      2: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(32'h0060_0000) - 32'h0030_0000;
    endcase
  endfunction

  function automatic logic [383:0] rnd_spring();
    logic [383:0] s;
    int mode;
    mode = $urandom_range(9);
    mode = (mode < 2) ? 0 : (mode < 3) ? 2 : (mode < 6) ? 1 : 3;
    for (int i = 0; i < 12; i++) s[32*i +: 32] = rnd_word(mode);
    if ($urandom_range(15) == 0) s[191:96] = s[95:0];
    else if ($urandom_range(7) == 0) s[32*(3+$urandom_range(2)) +: 32] = 0;
    return s;
  endfunction

  task automatic run_batch(int n);
    cfg_we <= 1'b0;
    for (int k = 0; k < n; k++) send_spring(rnd_spring());
  endtask

  initial begin
    logic [383:0] s;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    calm = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: coincident, unit axes, extremes
    send_spring('0);
    s = '0; s[96 +: 32] = 32'h0001_0000; send_spring(s);
    s = '0; s[128 +: 32] = 32'h0002_0000; s[224 +: 32] = 32'h0001_0000; send_spring(s);
    s = '0; s[160 +: 32] = 32'hFFFF_0000; s[352 +: 32] = 32'h0003_0000; send_spring(s);
    s = '0; s[0 +: 32] = 32'h8000_0000; s[96 +: 32] = 32'h7FFF_FFFF; send_spring(s);
    s = {12{32'h7FFF_FFFF}}; s[191:96] = {3{32'h8000_0000}}; send_spring(s);
    s = {12{32'h8000_0000}}; s[191:96] = {3{32'h7FFF_FFFF}}; send_spring(s);
    s = {12{32'hFFFF_FFFF}}; send_spring(s);
    s = '0; s[96 +: 32] = 32'd1; send_spring(s);
    s = '0; s[96 +: 96] = {3{32'h7FFF_FFFF}}; s[383:192] = {6{32'h8000_0000}};
    send_spring(s);
    run_batch(10);
    drain();

    write_reg(dsf_pkg::CFG_STIFFNESS, 32'hFFFF_FFFF);
    write_reg(dsf_pkg::CFG_DAMPING, 32'hFFFF_FFFF);
    write_reg(dsf_pkg::CFG_REST, 32'd0);
    write_reg(2'd3, 32'h1234_5678);
    run_batch(100);
    drain();

    write_reg(dsf_pkg::CFG_STIFFNESS, 32'd0);
    write_reg(dsf_pkg::CFG_DAMPING, 32'd0);
    write_reg(dsf_pkg::CFG_REST, 32'hFFFF_FFFF);
    run_batch(80);
    drain();

    write_reg(dsf_pkg::CFG_STIFFNESS, {$urandom});
    write_reg(dsf_pkg::CFG_DAMPING, {$urandom});
    write_reg(dsf_pkg::CFG_REST, $urandom_range(32'h0040_0000));
    run_batch(150);
    drain();

    write_reg(dsf_pkg::CFG_STIFFNESS, 32'd1310720);
    write_reg(dsf_pkg::CFG_DAMPING, 32'd13107);
    write_reg(dsf_pkg::CFG_REST, 32'h0002_0000);
    run_batch(150);
    calm = 1;
    run_batch(150);
    in_tvalid <= 1'b0;

    while (board.pending_forces.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.errors == 0) $display("[damped_spring_force] OK");
    else $display("[damped_spring_force] ERROR");
    $finish;
  end
endmodule

`default_nettype wire

// ----- files.f -----
sv/dsf_pkg.sv
sv/dsf_sqrt.sv
sv/dsf_div.sv
sv/damped_spring_force.sv
tb/sv/tb_top.sv
